// ===== rtl/lsr_pkg.sv =====
// lsr_pkg: shared types and constants of the lifo stack with reverse
package lsr_pkg;

    localparam int OpWidth       = 2;
    localparam int ValueWidth    = 32;
    localparam int CountOutWidth = 7;
    localparam int StatusWidth   = 2;

    typedef enum logic [OpWidth-1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_REVERSE = 2'd2,
        OP_CLEAR   = 2'd3
    } lsr_op_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } lsr_status_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_PUSH,
        CMD_PUSH_FULL,
        CMD_POP,
        CMD_POP_EMPTY,
        CMD_POP_LOAD,
        CMD_CLEAR,
        CMD_REV_SKIP,
        CMD_REV_START,
        CMD_REV_WR_LO,
        CMD_REV_WR_HI
    } lsr_cmd_t;

    typedef struct packed {
        lsr_cmd_t cmd;
        logic     finish;
    } lsr_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic rev_short;
        logic rev_more;
        logic out_free;
    } lsr_stat_t;

endpackage

// ===== rtl/lsr_in_if.sv =====
// lsr_in_if: input item channel with opcode and push value
interface lsr_in_if
    import lsr_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [OpWidth-1:0]           opcode;
    logic signed [ValueWidth-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink (input valid, input opcode, input push_value, output ready);
endinterface

// ===== rtl/lsr_out_if.sv =====
// lsr_out_if: result item channel with popped value, top, count and status
interface lsr_out_if
    import lsr_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [ValueWidth-1:0] popped_value;
    logic signed [ValueWidth-1:0] top_value;
    logic [CountOutWidth-1:0]     entry_count;
    logic [StatusWidth-1:0]       status;

    modport source (
        output valid, output popped_value, output top_value,
        output entry_count, output status, input ready
    );
    modport sink (
        input valid, input popped_value, input top_value,
        input entry_count, input status, output ready
    );
endinterface

// ===== rtl/lifo_stack_with_reverse.sv =====
// lifo_stack_with_reverse: top level of the stack with push, pop, reverse and clear
// push, clear and push on full: result register loaded when the item is accepted
// pop: result loaded on accept when it empties the stack, otherwise after the new top is read from the store
// reverse: a start read, then two swap writes per pair (low, then high) through one write port
// one item at a time; the next item is taken once the result register is free
// reset clears the count and the result valid flag; the store and the result data hold no reset value
module lifo_stack_with_reverse
    import lsr_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH  = 32
) (
    input logic clk,
    input logic rst_n,
    lsr_in_if.sink    in_ch,
    lsr_out_if.source out_ch
);

    lsr_ctrl_t ctrl;
    lsr_stat_t stat;

    lsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .opcode   (in_ch.opcode),
        .stat     (stat),
        .in_ready (in_ch.ready),
        .ctrl     (ctrl)
    );

    lsr_datapath #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .push_value   (in_ch.push_value),
        .out_ready    (out_ch.ready),
        .stat         (stat),
        .out_valid    (out_ch.valid),
        .popped_value (out_ch.popped_value),
        .top_value    (out_ch.top_value),
        .entry_count  (out_ch.entry_count),
        .status       (out_ch.status)
    );

endmodule

// ===== rtl/lsr_ram.sv =====
// lsr_ram: generic single write port, dual read port ram with registered read
module lsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/lsr_ctrl.sv =====
// lsr_ctrl: controller state machine that sequences push, pop, clear and reverse
module lsr_ctrl
    import lsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [OpWidth-1:0] opcode,
    input  lsr_stat_t          stat,
    output logic               in_ready,
    output lsr_ctrl_t          ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_LOAD,
        S_REV_LO,
        S_REV_HI
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE) && stat.out_free;
        ctrl.cmd    = CMD_IDLE;
        ctrl.finish = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (lsr_op_t'(opcode))
                        OP_PUSH:
                        begin
                            ctrl.cmd    = stat.full ? CMD_PUSH_FULL : CMD_PUSH;
                            ctrl.finish = 1'b1;
                        end
                        OP_POP:
                        begin
                            if (stat.empty)
                            begin
                                ctrl.cmd    = CMD_POP_EMPTY;
                                ctrl.finish = 1'b1;
                            end
                            else
                            begin
                                ctrl.cmd    = CMD_POP;
                                ctrl.finish = stat.single;
                                if (!stat.single)
                                begin
                                    state_next = S_POP_LOAD;
                                end
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (stat.rev_short)
                            begin
                                ctrl.cmd    = CMD_REV_SKIP;
                                ctrl.finish = 1'b1;
                            end
                            else
                            begin
                                ctrl.cmd   = CMD_REV_START;
                                state_next = S_REV_LO;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ctrl.cmd    = CMD_CLEAR;
                            ctrl.finish = 1'b1;
                        end
                        default:
                        begin
                            ctrl.cmd = CMD_IDLE;
                        end
                    endcase
                end
            end
            S_POP_LOAD:
            begin
                ctrl.cmd    = CMD_POP_LOAD;
                ctrl.finish = 1'b1;
                state_next  = S_IDLE;
            end
            S_REV_LO:
            begin
                ctrl.cmd   = CMD_REV_WR_LO;
                state_next = S_REV_HI;
            end
            S_REV_HI:
            begin
                ctrl.cmd = CMD_REV_WR_HI;
                if (stat.rev_more)
                begin
                    state_next = S_REV_LO;
                end
                else
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/lsr_datapath.sv =====
// lsr_datapath: count, top word, swap pointers, word store and result register
module lsr_datapath
    import lsr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsr_ctrl_t                    ctrl,
    input  logic signed [ValueWidth-1:0] push_value,
    input  logic                         out_ready,
    output lsr_stat_t                    stat,
    output logic                         out_valid,
    output logic signed [ValueWidth-1:0] popped_value,
    output logic signed [ValueWidth-1:0] top_value,
    output logic [CountOutWidth-1:0]     entry_count,
    output logic [StatusWidth-1:0]       status
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);

    logic [CntW-1:0]         count_reg;
    logic [CntW-1:0]         count_next;
    logic signed [WIDTH-1:0] top_reg;
    logic signed [WIDTH-1:0] top_next;
    logic signed [WIDTH-1:0] popped_reg;
    logic signed [WIDTH-1:0] popped_next;
    logic [AW-1:0]           lo_reg;
    logic [AW-1:0]           lo_next;
    logic [AW-1:0]           hi_reg;
    logic [AW-1:0]           hi_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [ValueWidth-1:0] out_popped_reg;
    logic signed [ValueWidth-1:0] out_top_reg;
    logic [CountOutWidth-1:0]     out_count_reg;
    logic [StatusWidth-1:0]       out_status_reg;

    logic signed [WIDTH-1:0] push_word;
    logic signed [WIDTH-1:0] res_popped;
    lsr_status_t             status_code;
    logic [CntW-1:0]         count_m1;
    logic [CntW-1:0]         count_m2;
    logic [AW:0]             lo_plus2;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic [WIDTH-1:0]        wdata;
    logic                    re;
    logic [AW-1:0]           raddr_a;
    logic [AW-1:0]           raddr_b;
    logic [WIDTH-1:0]        rdata_a;
    logic [WIDTH-1:0]        rdata_b;

    lsr_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign push_word = WIDTH'(push_value);
    assign count_m1  = count_reg - CntW'(1);
    assign count_m2  = count_reg - CntW'(2);
    assign lo_plus2  = {1'b0, lo_reg} + (AW+1)'(2);

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CntW'(DEPTH));
    assign stat.single    = (count_reg == CntW'(1));
    assign stat.rev_short = (count_reg < CntW'(2));
    assign stat.rev_more  = (lo_plus2 < {1'b0, hi_reg});
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next  = count_reg;
        top_next    = top_reg;
        popped_next = popped_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        raddr_a     = '0;
        raddr_b     = '0;
        res_popped  = '0;
        status_code = ST_OK;
        case (ctrl.cmd)
            CMD_PUSH:
            begin
                we         = 1'b1;
                waddr      = count_reg[AW-1:0];
                wdata      = push_word;
                top_next   = push_word;
                count_next = count_reg + CntW'(1);
            end
            CMD_PUSH_FULL:
            begin
                status_code = ST_PUSH_FULL;
            end
            CMD_POP:
            begin
                popped_next = top_reg;
                res_popped  = top_reg;
                count_next  = count_m1;
                re          = !stat.single;
                raddr_a     = count_m2[AW-1:0];
            end
            CMD_POP_EMPTY:
            begin
                res_popped  = '1;
                status_code = ST_POP_EMPTY;
            end
            CMD_POP_LOAD:
            begin
                top_next   = rdata_a;
                res_popped = popped_reg;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_REV_START:
            begin
                lo_next = '0;
                hi_next = count_m1[AW-1:0];
                re      = 1'b1;
                raddr_a = '0;
                raddr_b = count_m1[AW-1:0];
            end
            CMD_REV_WR_LO:
            begin
                we    = 1'b1;
                waddr = lo_reg;
                wdata = rdata_b;
                // old bottom becomes the new top
                if (lo_reg == '0)
                begin
                    top_next = rdata_a;
                end
            end
            CMD_REV_WR_HI:
            begin
                we      = 1'b1;
                waddr   = hi_reg;
                wdata   = rdata_a;
                lo_next = lo_reg + AW'(1);
                hi_next = hi_reg - AW'(1);
                re      = stat.rev_more;
                raddr_a = lo_reg + AW'(1);
                raddr_b = hi_reg - AW'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        popped_reg <= popped_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        if (ctrl.finish)
        begin
            out_popped_reg <= ValueWidth'(res_popped);
            out_top_reg    <= (count_next == '0) ? '1 : ValueWidth'(top_next);
            out_count_reg  <= CountOutWidth'(count_next);
            out_status_reg <= status_code;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign top_value    = out_top_reg;
    assign entry_count  = out_count_reg;
    assign status       = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("stack count above depth");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cmd == CMD_PUSH |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("push did not advance count");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == CMD_REV_WR_LO || ctrl.cmd == CMD_REV_WR_HI) |-> lo_reg < hi_reg)
        else $error("reverse pointers crossed");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> stat.out_free)
        else $error("result overwrites an item not yet taken");

endmodule
